[src/phase_modulated_cosine_shaper_macros.svh]
// Assertion macros for the shaper's checker file.
`ifndef PHASE_MODULATED_COSINE_SHAPER_MACROS_SVH
`define PHASE_MODULATED_COSINE_SHAPER_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define PMCS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

// Clocked assertion that also holds during reset.
`define PMCS_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

[src/pmcs_pkg.sv]
// Types, constants and register codes of the phase modulated cosine shaper.
`timescale 1ns / 1ps

package pmcs_pkg;

	localparam int TURN_W     = 32;
	localparam int FIELD_W    = 16;
	localparam int WAVE_W     = 18;
	localparam int CFG_IDX_W  = 8;

	localparam int SINE_LAT   = 8;
	localparam int MOD_LAT    = 4;
	localparam int OUT_LAT    = 2;
	localparam int PMCS_LATENCY = 1 + SINE_LAT + MOD_LAT + SINE_LAT + OUT_LAT;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_SHIFT  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ECCENTRICITY = 8'd3;

	localparam logic [FIELD_W-1:0] RST_AMPLITUDE    = 16'd8192;
	localparam logic [FIELD_W-1:0] RST_DC_OFFSET    = 16'd8192;
	localparam logic [FIELD_W-1:0] RST_PHASE_SHIFT  = 16'd0;
	localparam logic [FIELD_W-1:0] RST_ECCENTRICITY = 16'd0;

	// quarter-wave sine polynomial, Q30
	localparam logic [30:0] Q30_ONE = 31'd1073741824;
	localparam logic [30:0] SIN_C1  = 31'd1686629713;
	localparam logic [30:0] SIN_C3  = 31'd693598668;
	localparam logic [30:0] SIN_C5  = 31'd85569306;
	localparam logic [30:0] SIN_C7  = 31'd5026995;
	localparam logic [30:0] SIN_C9  = 31'd172272;
	localparam logic [14:0] SIN_MAX = 15'd16384;

	// round(2^32 / (2*pi)), turn per radian
	localparam logic signed [30:0] TURN_PER_RAD = 31'sd683565276;
	localparam logic [TURN_W-1:0]  QUARTER_TURN = 32'h4000_0000;

	typedef struct packed {
		logic signed [FIELD_W-1:0] amplitude;
		logic signed [FIELD_W-1:0] dc_offset;
		logic        [FIELD_W-1:0] phase_shift;
		logic signed [FIELD_W-1:0] eccentricity;
	} pmcs_cfg_t;

endpackage

[src/pmcs_cfg_regs.sv]
// Configuration register file of the shaper.
`timescale 1ns / 1ps

module pmcs_cfg_regs import pmcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [FIELD_W-1:0]   wr_data,
	output pmcs_cfg_t            cfg
);

	pmcs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude    <= RST_AMPLITUDE;
			cfg_q.dc_offset    <= RST_DC_OFFSET;
			cfg_q.phase_shift  <= RST_PHASE_SHIFT;
			cfg_q.eccentricity <= RST_ECCENTRICITY;
		end else if (wr_en) begin
			case (wr_index)
				REG_AMPLITUDE:    cfg_q.amplitude    <= wr_data;
				REG_DC_OFFSET:    cfg_q.dc_offset    <= wr_data;
				REG_PHASE_SHIFT:  cfg_q.phase_shift  <= wr_data;
				REG_ECCENTRICITY: cfg_q.eccentricity <= wr_data;
				default: ;  // unknown index: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/pmcs_sine.sv]
// Eight-stage sine of a 32-bit turn, Q1.14 result.
`timescale 1ns / 1ps

module pmcs_sine import pmcs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [TURN_W-1:0]        turn,
	output logic                     out_valid,
	output logic signed [FIELD_W-1:0] sine
);

	logic [SINE_LAT-1:0] v_q;

	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6, quad_s7;
	logic [30:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic [30:0] p_s3, p_s4, p_s5, p_s6;
	logic [30:0] q_s7;
	logic signed [FIELD_W-1:0] m_s8;

	logic [30:0] x_in;
	logic [61:0] mul_x2, mul_p3, mul_p4, mul_p5, mul_p6, mul_q;
	logic [31:0] q_rnd;
	logic [15:0] m_raw;
	logic [14:0] m_cap;

	// fold onto the first quadrant
	assign x_in = turn[30] ? (Q30_ONE - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};

	assign mul_x2 = 62'(x_s1) * 62'(x_s1);
	assign mul_p3 = 62'(x2_s2) * 62'(SIN_C9);
	assign mul_p4 = 62'(x2_s3) * 62'(p_s3);
	assign mul_p5 = 62'(x2_s4) * 62'(p_s4);
	assign mul_p6 = 62'(x2_s5) * 62'(p_s5);
	assign mul_q  = 62'(x_s6) * 62'(p_s6);

	assign q_rnd = {1'b0, q_s7} + 32'd32768;
	assign m_raw = q_rnd[31:16];
	assign m_cap = (m_raw > 16'(SIN_MAX)) ? SIN_MAX : m_raw[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[SINE_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_in;
		quad_s1 <= turn[31:30];

		x2_s2   <= mul_x2[60:30];
		x_s2    <= x_s1;
		quad_s2 <= quad_s1;

		p_s3    <= SIN_C7 - mul_p3[60:30];
		x2_s3   <= x2_s2;
		x_s3    <= x_s2;
		quad_s3 <= quad_s2;

		p_s4    <= SIN_C5 - mul_p4[60:30];
		x2_s4   <= x2_s3;
		x_s4    <= x_s3;
		quad_s4 <= quad_s3;

		p_s5    <= SIN_C3 - mul_p5[60:30];
		x2_s5   <= x2_s4;
		x_s5    <= x_s4;
		quad_s5 <= quad_s4;

		p_s6    <= SIN_C1 - mul_p6[60:30];
		x_s6    <= x_s5;
		quad_s6 <= quad_s5;

		q_s7    <= mul_q[60:30];
		quad_s7 <= quad_s6;

		m_s8    <= quad_s7[1] ? -$signed({1'b0, m_cap}) : $signed({1'b0, m_cap});
	end

	assign out_valid = v_q[SINE_LAT-1];
	assign sine      = m_s8;

endmodule

[src/pmcs_phase_mod.sv]
// Inner phase modulation: ecc*sin scaled to a turn, added, plus a quarter turn.
`timescale 1ns / 1ps

module pmcs_phase_mod import pmcs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [TURN_W-1:0]         turn,
	input  logic signed [FIELD_W-1:0] sine,
	input  logic signed [FIELD_W-1:0] eccentricity,
	output logic                      out_valid,
	output logic [TURN_W-1:0]         cos_turn
);

	logic [MOD_LAT-1:0] v_q;

	logic signed [30:0] mod_e1;
	logic signed [59:0] prod_e2;
	logic [TURN_W-1:0]  t_e1, t_e2, t_e3;
	logic [TURN_W-1:0]  dturn_e3;
	logic [TURN_W-1:0]  tc_e4;

	logic signed [31:0] mul_mod;
	logic signed [61:0] mul_turn;
	logic signed [59:0] rnd_sum;

	assign mul_mod  = eccentricity * sine;
	assign mul_turn = 62'(mod_e1) * 62'(TURN_PER_RAD);
	// ties away from zero: bias one less on negative values
	assign rnd_sum  = prod_e2 + (prod_e2[59] ? 60'sd33554431 : 60'sd33554432);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[MOD_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		mod_e1   <= mul_mod[30:0];
		t_e1     <= turn;
		prod_e2  <= mul_turn[59:0];
		t_e2     <= t_e1;
		dturn_e3 <= rnd_sum[57:26];
		t_e3     <= t_e2;
		tc_e4    <= t_e3 + dturn_e3 + QUARTER_TURN;
	end

	assign out_valid = v_q[MOD_LAT-1];
	assign cos_turn  = tc_e4;

endmodule

[src/phase_modulated_cosine_shaper.sv]
// Top level of the phase modulated cosine shaper.
//
//  channel   ports                                   request moves when
//  --------  --------------------------------------  --------------------------
//  input     start, busy, phase_in                   start && !busy at clk rise
//  result    done, wave_out                          done high, one cycle only
//  config    cfg_valid, cfg_ready, cfg_index,        cfg_valid && cfg_ready
//            cfg_data
//
// One request is taken every cycle; busy never rises.
// From accept to done a request passes one phase-add stage,
// two eight-stage sine pipelines (six multipliers each), four modulation
// stages and two output stages; the sine pipelines hold most of the stages.
// arst_n clears the valid bits and loads the register defaults.
// The receiver cannot stall, so no stage ever holds.
//
// wave_out = amplitude * cos(theta + eccentricity * sin(theta)) + dc_offset,
// theta = (phase_in + phase_shift) mod one turn.
`timescale 1ns / 1ps

module phase_modulated_cosine_shaper import pmcs_pkg::*; #(
	parameter int PHASE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      start,
	output logic                      busy,
	input  logic [FIELD_W-1:0]        phase_in,

	output logic                      done,
	output logic signed [WAVE_W-1:0]  wave_out,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [FIELD_W-1:0]        cfg_data
);

	pmcs_cfg_t cfg;

	logic accept;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	pmcs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// ---- stage 1: phase add, wrap at PHASE_BITS, left-align to a 32-bit turn
	// Missing high bits read as zero when PHASE_BITS exceeds the field width.
	logic [FIELD_W+TURN_W-1:0] in_wide, shift_wide;
	logic [PHASE_BITS-1:0]     ph_sum;
	logic [TURN_W-1:0]         t_s1;
	logic                      valid_s1;

	assign in_wide    = {{TURN_W{1'b0}}, phase_in};
	assign shift_wide = {{TURN_W{1'b0}}, cfg.phase_shift};
	assign ph_sum     = in_wide[PHASE_BITS-1:0] + shift_wide[PHASE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= TURN_W'(ph_sum) << (TURN_W - PHASE_BITS);
	end

	// ---- outer sine, with the turn carried alongside
	logic                      sin_valid;
	logic signed [FIELD_W-1:0] sin_val;
	logic [TURN_W-1:0]         t_dly_q [SINE_LAT];

	pmcs_sine u_sin (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.turn      (t_s1),
		.out_valid (sin_valid),
		.sine      (sin_val)
	);

	always_ff @(posedge clk) begin
		t_dly_q[0] <= t_s1;
		for (int i = 1; i < SINE_LAT; i++) begin
			t_dly_q[i] <= t_dly_q[i-1];
		end
	end

	// ---- modulation of the turn
	logic              mod_valid;
	logic [TURN_W-1:0] cos_turn;

	pmcs_phase_mod u_mod (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (sin_valid),
		.turn         (t_dly_q[SINE_LAT-1]),
		.sine         (sin_val),
		.eccentricity (cfg.eccentricity),
		.out_valid    (mod_valid),
		.cos_turn     (cos_turn)
	);

	// ---- cosine as sine of the turn plus a quarter
	logic                      cos_valid;
	logic signed [FIELD_W-1:0] cos_val;

	pmcs_sine u_cos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mod_valid),
		.turn      (cos_turn),
		.out_valid (cos_valid),
		.sine      (cos_val)
	);

	// ---- output: amplitude product, round Q28 to Q14 away from zero, add dc
	logic                      valid_f1, valid_f2;
	logic signed [31:0]        mul_amp;
	logic signed [31:0]        prod_f1;
	logic signed [31:0]        rnd_f;
	logic signed [WAVE_W-1:0]  wave_f2;

	assign mul_amp = cfg.amplitude * cos_val;
	assign rnd_f   = prod_f1 + (prod_f1[31] ? 32'sd8191 : 32'sd8192);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_f1 <= 1'b0;
			valid_f2 <= 1'b0;
		end else begin
			valid_f1 <= cos_valid;
			valid_f2 <= valid_f1;
		end
	end

	always_ff @(posedge clk) begin
		prod_f1 <= mul_amp;
		wave_f2 <= rnd_f[31:14] + WAVE_W'(cfg.dc_offset);
	end

	assign done     = valid_f2;
	assign wave_out = wave_f2;

endmodule

[src/pmcs_chk.sv]
// Port-level checks of the shaper and their bind.
`timescale 1ns / 1ps
`include "phase_modulated_cosine_shaper_macros.svh"

module pmcs_chk import pmcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);

	// every accepted request comes back after the fixed latency
	`PMCS_ASSERT(a_lat_fwd, clk, arst_n, (start && !busy) |-> ##PMCS_LATENCY done, "accepted request gave no result")

	// no result without a request the same distance back
	`PMCS_ASSERT(a_lat_bwd, clk, arst_n, done |-> $past(start && !busy, PMCS_LATENCY), "result without request")

	// both the input side and the config side take a request every cycle
	`PMCS_ASSERT_NR(a_always_open, clk, !busy && cfg_ready, "input or config side held off")

endmodule

bind phase_modulated_cosine_shaper pmcs_chk u_pmcs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready)
);

[tb/phase_modulated_cosine_shaper_test.sv]
// Self-checking testbench for the phase modulated cosine shaper.
`timescale 1ns / 1ps

module phase_modulated_cosine_shaper_test;
	import pmcs_pkg::*;

	localparam int PHASE_BITS = 16;

	// Register indexes with no register behind them; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

	// Sender idle rates of the three random sections, percent of cycles.
	localparam int unsigned GAP_LIGHT = 27;
	localparam int unsigned GAP_HEAVY = 85;
	localparam int unsigned GAP_NONE  = 0;
	localparam int          SECTION_ITEMS = 517;

	// What the driver pulls off its queue: a phase sample, a register write,
	// or a pause that holds the sender until the pipeline is empty.
	typedef enum logic [1:0] {
		REQ_PHASE,
		REQ_CFG,
		REQ_DRAIN
	} req_kind_t;

	typedef struct {
		req_kind_t           kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [FIELD_W-1:0]  data;
		int unsigned         gap_pct;
	} pend_req_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      start     = 1'b0;
	logic [FIELD_W-1:0]        phase_in  = '0;
	logic                      cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [FIELD_W-1:0]        cfg_data  = '0;
	logic                      busy;
	logic                      done;
	logic signed [WAVE_W-1:0]  wave_out;
	logic                      cfg_ready;

	pend_req_t              pend_q[$];   // stimulus not yet handed to the block
	logic [WAVE_W-1:0]      wave_q[$];   // predicted wave samples, oldest first
	pmcs_cfg_t              shaper_cfg;  // register copy used by the predictor
	int unsigned            n_sent = 0;  // samples accepted by the block
	int unsigned            n_recv = 0;  // samples returned on done
	int unsigned            n_errors = 0;

	phase_modulated_cosine_shaper #(
		.PHASE_BITS(PHASE_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.phase_in  (phase_in),
		.done      (done),
		.wave_out  (wave_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// sin(pi/2 * x), x in Q30 on [0, 1]; odd polynomial in Horner form, Q30 out.
	function automatic longint quarter_wave_q30(longint x);
		longint x2;
		longint p;
		x2 = (x * x) >>> 30;
		p = longint'(SIN_C9);
		p = longint'(SIN_C7) - ((x2 * p) >>> 30);
		p = longint'(SIN_C5) - ((x2 * p) >>> 30);
		p = longint'(SIN_C3) - ((x2 * p) >>> 30);
		p = longint'(SIN_C1) - ((x2 * p) >>> 30);
		return (x * p) >>> 30;
	endfunction

	// Sine of a 32-bit turn in Q1.14: fold to the first quadrant, round half
	// up from Q30, clip at one, then negate in the upper half-turn.
	function automatic longint sine_turn_q14(logic [TURN_W-1:0] t);
		longint f;
		longint x;
		longint m;
		f = longint'(t[29:0]);
		x = t[30] ? (longint'(Q30_ONE) - f) : f;
		m = (quarter_wave_q30(x) + 64'sd32768) >>> 16;
		if (m > longint'(SIN_MAX))
			m = longint'(SIN_MAX);
		return t[31] ? -m : m;
	endfunction

	// a / 2^sh, rounded to nearest with ties away from zero.
	function automatic longint round_away(longint a, int sh);
		longint mag;
		longint r;
		mag = (a < 0) ? -a : a;
		r = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
		return (a < 0) ? -r : r;
	endfunction

	function automatic logic [WAVE_W-1:0] predict_wave(logic [FIELD_W-1:0] ph_in);
		longint            pmask;
		longint            ph;
		logic [TURN_W-1:0] theta;
		logic [TURN_W-1:0] theta_mod;
		longint            s;
		longint            dturn;
		longint            c;
		longint            y;
		pmask = (64'sd1 <<< PHASE_BITS) - 1;
		ph = ((longint'(ph_in) & pmask) + (longint'(shaper_cfg.phase_shift) & pmask)) & pmask;
		theta = TURN_W'(ph << (TURN_W - PHASE_BITS));
		s = sine_turn_q14(theta);
		// eccentricity * sin is Q26 radians; convert to a 32-bit turn offset
		dturn = round_away(longint'($signed(shaper_cfg.eccentricity)) * s
			* longint'(TURN_PER_RAD), 26);
		theta_mod = theta + dturn[TURN_W-1:0];
		c = sine_turn_q14(theta_mod + QUARTER_TURN);
		y = round_away(longint'($signed(shaper_cfg.amplitude)) * c, 14)
			+ longint'($signed(shaper_cfg.dc_offset));
		return y[WAVE_W-1:0];
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
		case (idx)
		REG_AMPLITUDE:    shaper_cfg.amplitude    = val;
		REG_DC_OFFSET:    shaper_cfg.dc_offset    = val;
		REG_PHASE_SHIFT:  shaper_cfg.phase_shift  = val;
		REG_ECCENTRICITY: shaper_cfg.eccentricity = val;
		default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string what, logic [WAVE_W-1:0] want,
		logic [WAVE_W-1:0] got);
		n_errors++;
		if (n_errors <= 10)
			$display("[%0t] %s: expected wave_out %0d, got %0d", $time, what,
				$signed(want), $signed(got));
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus queue helpers
	// ---------------------------------------------------------------------

	function automatic void push_phase(logic [FIELD_W-1:0] ph, int unsigned gap);
		pend_q.push_back('{REQ_PHASE, '0, ph, gap});
	endfunction

	function automatic void push_cfg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
		pend_q.push_back('{REQ_CFG, idx, val, 0});
	endfunction

	// Edge values of a 16-bit field with a fair share, otherwise anything.
	function automatic logic [FIELD_W-1:0] pick_field();
		case ($urandom_range(7))
		0: return 16'h7FFF;
		1: return 16'h8000;
		2: return 16'h0000;
		3: return 16'hFFFF;
		default: return FIELD_W'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// New random register set; now and then a write to a dead index too.
	function automatic void push_random_cfg();
		push_cfg(REG_AMPLITUDE, pick_field());
		push_cfg(REG_DC_OFFSET, pick_field());
		push_cfg(REG_PHASE_SHIFT, pick_field());
		push_cfg(REG_ECCENTRICITY, pick_field());
		if ($urandom_range(3) == 0)
			push_cfg($urandom_range(1) ? REG_UNUSED_HI : REG_UNUSED_LO, pick_field());
	endfunction

	function automatic void push_section(int unsigned gap);
		for (int i = 0; i < SECTION_ITEMS; i++) begin
			if (i % 64 == 0)
				push_random_cfg();
			// hold the sender until everything in flight has come back
			if (i == SECTION_ITEMS / 2)
				pend_q.push_back('{REQ_DRAIN, '0, '0, 0});
			// quadrant corners now and then, full-range phase otherwise
			if ($urandom_range(7) == 0)
				push_phase(FIELD_W'($urandom_range(4) * 16'h4000 - ($urandom_range(1))), gap);
			else
				push_phase(FIELD_W'($urandom_range(16'hFFFF)), gap);
		end
	endfunction

	// ---------------------------------------------------------------------
	// Driver: one request at a time from pend_q. The accepted sample is
	// predicted in the same edge it is taken, from the phase still on the
	// port. Register writes and drains wait until the pipeline is empty;
	// n_sent/n_recv are both updated by NBA, so the idle test is race free.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : drive_proc
		logic      hold;
		logic      took;
		logic      nxt_start;
		logic      nxt_cfg;
		pend_req_t head;
		hold = 1'b0;
		took = 1'b0;
		if (start) begin
			if (!busy) begin
				wave_q.push_back(predict_wave(phase_in));
				took = 1'b1;
			end else begin
				hold = 1'b1;
			end
		end
		if (cfg_valid) begin
			if (cfg_ready)
				apply_reg_write(cfg_index, cfg_data);
			else
				hold = 1'b1;
		end
		nxt_start = hold & start;
		nxt_cfg   = hold & cfg_valid;
		if (arst_n && !hold && pend_q.size() != 0) begin
			head = pend_q[0];
			case (head.kind)
			REQ_PHASE: begin
				if ($urandom_range(99) >= head.gap_pct) begin
					phase_in <= head.data;
					nxt_start = 1'b1;
					void'(pend_q.pop_front());
				end
			end
			REQ_CFG: begin
				if (!took && n_sent == n_recv) begin
					cfg_index <= head.idx;
					cfg_data <= head.data;
					nxt_cfg = 1'b1;
					void'(pend_q.pop_front());
				end
			end
			default: begin
				if (!took && n_sent == n_recv)
					void'(pend_q.pop_front());
			end
			endcase
		end
		if (took)
			n_sent <= n_sent + 1;
		start <= nxt_start;
		cfg_valid <= nxt_cfg;
	end

	// ---------------------------------------------------------------------
	// Monitor: done is a one-cycle strobe, sampled at the edge ending it.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : watch_proc
		logic [WAVE_W-1:0] want;
		if (arst_n && done === 1'b1) begin
			n_recv <= n_recv + 1;
			if (wave_q.size() == 0) begin
				note_mismatch("result with nothing outstanding", 'x, wave_out);
			end else begin
				want = wave_q.pop_front();
				if (wave_out !== want)
					note_mismatch("wave_out mismatch", want, wave_out);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ---------------------------------------------------------------------
	initial begin : main_seq
		shaper_cfg.amplitude    = RST_AMPLITUDE;
		shaper_cfg.dc_offset    = RST_DC_OFFSET;
		shaper_cfg.phase_shift  = RST_PHASE_SHIFT;
		shaper_cfg.eccentricity = RST_ECCENTRICITY;

		// Reset defaults: quadrant points, wrap edge and alternating bit patterns.
		push_phase(16'h0000, 0);
		push_phase(16'h4000, 0);
		push_phase(16'h8000, 0);
		push_phase(16'hC000, 0);
		push_phase(16'hFFFF, 0);
		push_phase(16'h5555, 0);
		push_phase(16'hAAAA, 0);

		// Most negative gain against dc extremes: cos = +1 and -1 give the
		// lowest and highest sums the output can take.
		push_cfg(REG_AMPLITUDE, 16'h8000);
		push_cfg(REG_DC_OFFSET, 16'h8000);
		push_phase(16'h0000, 0);
		push_cfg(REG_DC_OFFSET, 16'h7FFF);
		push_phase(16'h8000, 0);

		// Largest modulation depth, phase shift that wraps the sum.
		push_cfg(REG_AMPLITUDE, 16'h7FFF);
		push_cfg(REG_ECCENTRICITY, 16'h7FFF);
		push_cfg(REG_PHASE_SHIFT, 16'hFFFF);
		push_phase(16'h0001, 0);
		push_phase(16'h4001, 0);
		push_phase(16'hC000, 0);
		push_phase(16'h2000, 0);

		// Negative depth, half-turn shift; then writes to dead indexes that
		// must leave the registers alone.
		push_cfg(REG_ECCENTRICITY, 16'h8000);
		push_cfg(REG_PHASE_SHIFT, 16'h8000);
		push_phase(16'h4000, 0);
		push_phase(16'h6000, 0);
		push_cfg(REG_UNUSED_LO, 16'h0000);
		push_cfg(REG_UNUSED_HI, 16'hFFFF);
		push_phase(16'h4000, 0);
		push_phase(16'hE000, 0);

		// Zero gain leaves the dc level alone.
		push_cfg(REG_AMPLITUDE, 16'h0000);
		push_cfg(REG_DC_OFFSET, 16'hFFFF);
		push_phase(16'h1234, 0);

		push_section(GAP_LIGHT);
		push_section(GAP_HEAVY);
		push_section(GAP_NONE);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || start || cfg_valid)
			@(posedge clk);
		while (n_sent != n_recv)
			@(posedge clk);
		repeat (PMCS_LATENCY + 4) @(posedge clk);

		if (wave_q.size() != 0) begin
			$display("%0d predicted samples never came back", wave_q.size());
			n_errors += wave_q.size();
		end

		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#(2_000_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/pmcs_pkg.sv
src/pmcs_cfg_regs.sv
src/pmcs_sine.sv
src/pmcs_phase_mod.sv
src/phase_modulated_cosine_shaper.sv
src/pmcs_chk.sv
tb/phase_modulated_cosine_shaper_test.sv
